[rtl/fac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fac_pkg
// shared types and constants of the frustum box culling core
// ----------------------------------------------------------------------------
package fac_pkg;

    localparam int ENTRY_W    = 32;
    localparam int CFG_W      = 64;
    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int FIELD_W    = 32;
    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANES = 6;
    localparam int S_TDATA_W  = 2 * NUM_AXES * FIELD_W;
    localparam int M_TDATA_W  = 8;
    localparam int DIST_SHIFT = 16;

    // identity matrix, two q16.16 entries per register
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    // one matrix row, entry of column c at [c]
    typedef logic [3:0][ENTRY_W-1:0] fac_row_t;

    // per-stage load strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } fac_adv_t;

endpackage : fac_pkg
`default_nettype wire

[rtl/frustum_aabb_cull_core.sv]
`default_nettype none
// path: a request passes the stage 1, 2 and 3 registers, then the output register
// throughput: one box per cycle unless a stalled output has filled the pipeline; all six planes evaluated in parallel
// stages: corner select, 33x32 multiply, pair add, final add and sign test
// a stalled output fills bubbles upstream before the input stalls
// reset: synchronous active-low, empties the pipeline and loads the identity
// ----------------------------------------------------------------------------
// frustum_aabb_cull_core
// view frustum test of axis-aligned boxes against a projection-view matrix
// ----------------------------------------------------------------------------
module frustum_aabb_cull_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [fac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fac_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [fac_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // visible, zero fill
    output logic [fac_pkg::M_TDATA_W-1:0]    m_tdata
);
    import fac_pkg::*;

    logic [CFG_W-1:0]              cfg_reg [NUM_CFG];
    fac_row_t                      row [4];
    logic signed [COORD_WIDTH-1:0] box_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] box_hi [NUM_AXES];
    logic [NUM_PLANES-1:0]         pass_vec;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, out_valid_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic [M_TDATA_W-1:0] out_data_reg;
    fac_adv_t adv;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            row[r] = {cfg_reg[2 * r + 1], cfg_reg[2 * r]};
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            box_lo[i] = $signed(s_tdata[i * FIELD_W +: COORD_WIDTH]);
            box_hi[i] = $signed(s_tdata[(NUM_AXES + i) * FIELD_W +: COORD_WIDTH]);
        end
    end

    // a stage loads when it is empty or its content moves on
    assign rdy4 = ~out_valid_reg | m_tready;
    assign rdy3 = ~s3_valid_reg | rdy4;
    assign rdy2 = ~s2_valid_reg | rdy3;
    assign rdy1 = ~s1_valid_reg | rdy2;

    assign adv.s1 = rdy1;
    assign adv.s2 = rdy2;
    assign adv.s3 = rdy3;

    always_comb begin
        s1_valid_next  = rdy1 ? s_tvalid     : s1_valid_reg;
        s2_valid_next  = rdy2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = rdy3 ? s2_valid_reg : s3_valid_reg;
        out_valid_next = rdy4 ? s3_valid_reg : out_valid_reg;
    end

    genvar gk, gs;
    generate
        for (gk = 0; gk < 3; gk++) begin : g_axis
            for (gs = 0; gs < 2; gs++) begin : g_side
                fac_plane #(
                    .COORD_WIDTH (COORD_WIDTH)
                ) u_plane (
                    .aclk   (aclk),
                    .adv    (adv),
                    .minus  (1'(gs)),
                    .row_w  (row[3]),
                    .row_k  (row[gk]),
                    .box_lo (box_lo),
                    .box_hi (box_hi),
                    .pass   (pass_vec[2 * gk + gs])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < NUM_CFG; r++) begin
                cfg_reg[r] <= CFG_RESET[r];
            end
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cfg_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            out_data_reg <= {{(M_TDATA_W - 1){1'b0}}, &pass_vec};
        end
    end

    assign s_tready = rdy1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted request did not enter stage 1");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg && !m_tready)
        |-> !s_tready)
        else $error("input ready while pipeline full and stalled");

    a_s3_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && rdy4) |=> out_valid_reg)
        else $error("stage 3 request lost on its way to the output");

    a_hold_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && !rdy4) |=> s3_valid_reg)
        else $error("stalled stage 3 request dropped");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s1_valid_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule : frustum_aabb_cull_core
`default_nettype wire

[rtl/fac_plane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fac_plane
// one clip plane: best-corner select, products, partial sums, sign test
// ----------------------------------------------------------------------------
module fac_plane #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  fac_pkg::fac_adv_t             adv,
    input  logic                          minus,
    input  fac_pkg::fac_row_t             row_w,
    input  fac_pkg::fac_row_t             row_k,
    input  logic signed [COORD_WIDTH-1:0] box_lo [fac_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] box_hi [fac_pkg::NUM_AXES],
    output logic                          pass
);
    import fac_pkg::*;

    localparam int COEF_W = ENTRY_W + 1;
    localparam int PROD_W = COEF_W + COORD_WIDTH;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [COEF_W-1:0]      coef [NUM_AXES];
    logic signed [COEF_W-1:0]      dist_coef;
    logic signed [COORD_WIDTH-1:0] sel [NUM_AXES];

    logic signed [COEF_W-1:0]      coef_reg [NUM_AXES];
    logic signed [COEF_W-1:0]      dist_reg;
    logic signed [COORD_WIDTH-1:0] coord_reg [NUM_AXES];
    logic signed [PROD_W-1:0]      prod_reg [NUM_AXES];
    logic signed [PROD_W-1:0]      dist_scaled;
    logic signed [PROD_W-1:0]      dist_scaled_reg;
    logic signed [PAIR_W-1:0]      sum_a_reg;
    logic signed [PAIR_W-1:0]      sum_b_reg;
    logic signed [SUM_W-1:0]       total;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            coef[i] = minus
                ? ($signed({row_w[i][ENTRY_W-1], row_w[i]})
                   - $signed({row_k[i][ENTRY_W-1], row_k[i]}))
                : ($signed({row_w[i][ENTRY_W-1], row_w[i]})
                   + $signed({row_k[i][ENTRY_W-1], row_k[i]}));
            // negative normal wants the smaller coordinate
            if (coef[i][COEF_W-1]) begin
                sel[i] = (box_lo[i] < box_hi[i]) ? box_lo[i] : box_hi[i];
            end else begin
                sel[i] = (box_lo[i] < box_hi[i]) ? box_hi[i] : box_lo[i];
            end
        end
        dist_coef = minus
            ? ($signed({row_w[3][ENTRY_W-1], row_w[3]})
               - $signed({row_k[3][ENTRY_W-1], row_k[3]}))
            : ($signed({row_w[3][ENTRY_W-1], row_w[3]})
               + $signed({row_k[3][ENTRY_W-1], row_k[3]}));
    end

    assign dist_scaled = PROD_W'(dist_reg) <<< DIST_SHIFT;

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                coef_reg[i]  <= coef[i];
                coord_reg[i] <= sel[i];
            end
            dist_reg <= dist_coef;
        end
        if (adv.s2) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                prod_reg[i] <= coef_reg[i] * coord_reg[i];
            end
            dist_scaled_reg <= dist_scaled;
        end
        if (adv.s3) begin
            sum_a_reg <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            sum_b_reg <= PAIR_W'(prod_reg[2]) + PAIR_W'(dist_scaled_reg);
        end
    end

    assign total = SUM_W'(sum_a_reg) + SUM_W'(sum_b_reg);
    assign pass  = ~total[SUM_W-1];

endmodule : fac_plane
`default_nettype wire
